FILE: src/assert_macros.svh
// Assertion macros for the RTL files; included by atapio_emit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/atapio_pkg.sv
// Types and constants of the ATA PIO transfer sequencer.
package atapio_pkg;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [3:0] OP_REG_WR     = 4'd0;
    localparam logic [3:0] OP_STATUS_RD  = 4'd1;
    localparam logic [3:0] OP_DELAY_RD   = 4'd2;
    localparam logic [3:0] OP_DATA_RD    = 4'd3;
    localparam logic [3:0] OP_DATA_WR    = 4'd4;
    localparam logic [3:0] OP_DELIVER    = 4'd5;
    localparam logic [3:0] OP_NEED_WORDS = 4'd6;
    localparam logic [3:0] OP_DONE_OK    = 4'd7;
    localparam logic [3:0] OP_DONE_ERR   = 4'd8;

    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_DRIVE   = 3'd6;
    localparam logic [2:0] REG_CMD     = 3'd7;

    localparam logic [7:0] CMD_READ48   = 8'h24;
    localparam logic [7:0] CMD_READ28   = 8'h20;
    localparam logic [7:0] CMD_WRITE48  = 8'h34;
    localparam logic [7:0] CMD_WRITE28  = 8'h30;
    localparam logic [7:0] CMD_FLUSH48  = 8'hEA;
    localparam logic [7:0] CMD_FLUSH28  = 8'hE7;
    localparam logic [7:0] DRV_BASE     = 8'hE0;
    localparam logic [7:0] DRV_SLAVE    = 8'h10;

    localparam int ST_BSY = 7;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [1:0] CFG_SLAVE_SELECT = 2'd0;
    localparam logic [1:0] CFG_USE_LBA48    = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT   = 2'd2;

    localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;

    // Last word index of a sector (256 words per sector).
    localparam logic [7:0] WORD_LAST = 8'hFF;

    // Sequence that follows the optional data word result.
    localparam logic [3:0] BODY_NONE     = 4'd0;
    localparam logic [3:0] BODY_STATUS   = 4'd1;
    localparam logic [3:0] BODY_DATARQ   = 4'd2;
    localparam logic [3:0] BODY_NEED     = 4'd3;
    localparam logic [3:0] BODY_DONE_OK  = 4'd4;
    localparam logic [3:0] BODY_DONE_ERR = 4'd5;
    localparam logic [3:0] BODY_FLUSH    = 4'd6;
    localparam logic [3:0] BODY_ISSUE28  = 4'd7;
    localparam logic [3:0] BODY_ISSUE48  = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic        write_dir;
        logic [31:0] start_lba;
        logic [31:0] sector_count;
        logic [7:0]  status_byte;
        logic [15:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  reg_index;
        logic [15:0] value;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        head_en;
        logic [3:0]  head_op;
        logic [15:0] head_val;
        logic [3:0]  body;
        logic [7:0]  drv;
        logic [31:0] lba;
        logic [8:0]  batch;
        logic        writing;
        logic        lba48;
    } t_plan;

endpackage

FILE: src/ata_pio_transfer_sequencer.sv
// Top level of the host-side ATA PIO sector transfer sequencer.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------
//  input    | in        | i_in_valid / o_in_ready   | i_in_item
//  result   | out       | o_out_valid / i_out_ready | o_out_item
//  config   | in        | i_cfg_wr_en, no wait      | i_cfg_index, i_cfg_wdata
//
// An accepted item updates the state in the cycle it is taken and loads a result
// plan; the plan sequencer sends one result per cycle while i_out_ready is high (none to 15 per item).
// A read data word yields 2 results, a write data word 1 to 3; a command issue 11 or 15.
// The next item is taken in the cycle the final result of the previous one transfers.
// Reset is synchronous. A stalled result holds intake.
module ata_pio_transfer_sequencer #(
    parameter int BATCH_SECTORS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  atapio_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output atapio_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [19:0]           i_cfg_wdata
);
    import atapio_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_BUSY  = 3'd1;
    localparam logic [2:0] PH_WAIT_DRQ   = 3'd2;
    localparam logic [2:0] PH_DATA_READ  = 3'd3;
    localparam logic [2:0] PH_DATA_WRITE = 3'd4;
    localparam logic [2:0] PH_FLUSH_WAIT = 3'd5;

    localparam logic [8:0]  BATCH_MAX9  = 9'(BATCH_SECTORS);
    localparam logic [31:0] BATCH_MAX32 = 32'(BATCH_SECTORS);

    logic        r_slave;
    logic        r_lba48;
    logic [19:0] r_poll_limit;

    logic [2:0]  r_phase,  n_phase;
    logic        r_writing, n_writing;
    logic [31:0] r_cur_lba, n_cur_lba;
    logic [31:0] r_left,   n_left;
    logic [8:0]  r_batch,  n_batch;
    logic [8:0]  r_sib,    n_sib;
    logic [7:0]  r_wi,     n_wi;
    logic [19:0] r_pc,     n_pc;

    t_plan       plan;
    logic        accept;
    logic        load;
    logic        emit_free;
    logic        do_sd;
    logic        do_eb;
    logic        do_retry;

    logic [31:0] eb_lba;
    logic [31:0] eb_left;
    logic [8:0]  eb_batch;
    logic [8:0]  st_batch;
    logic [8:0]  sd_sib;
    logic [19:0] pc_inc;
    logic [7:0]  st;

    assign st       = i_in_item.status_byte;
    assign eb_lba   = r_cur_lba + {23'd0, r_batch};
    assign eb_left  = r_left - {23'd0, r_batch};
    assign eb_batch = (eb_left > BATCH_MAX32) ? BATCH_MAX9 : eb_left[8:0];
    assign st_batch = (i_in_item.sector_count > BATCH_MAX32) ? BATCH_MAX9
                                                             : i_in_item.sector_count[8:0];
    assign sd_sib   = r_sib + 9'd1;
    assign pc_inc   = r_pc + 20'd1;

    assign o_in_ready = emit_free;
    assign accept     = i_in_valid && o_in_ready;
    assign load       = accept && (plan.head_en || plan.body != BODY_NONE);

    always_comb begin
        n_phase   = r_phase;
        n_writing = r_writing;
        n_cur_lba = r_cur_lba;
        n_left    = r_left;
        n_batch   = r_batch;
        n_sib     = r_sib;
        n_wi      = r_wi;
        n_pc      = r_pc;
        do_sd     = 1'b0;
        do_eb     = 1'b0;
        do_retry  = 1'b0;

        plan          = '0;
        plan.head_val = i_in_item.data_word;
        plan.body     = BODY_NONE;
        plan.drv      = DRV_BASE | (r_slave ? DRV_SLAVE : 8'h00)
                      | (r_lba48 ? 8'h00 : {4'h0, r_cur_lba[27:24]});
        plan.lba      = r_cur_lba;
        plan.batch    = r_batch;
        plan.writing  = r_writing;
        plan.lba48    = r_lba48;

        case (i_in_item.kind)
            KIND_START: begin
                if (r_phase == PH_IDLE) begin
                    n_writing = i_in_item.write_dir;
                    n_cur_lba = i_in_item.start_lba;
                    n_left    = i_in_item.sector_count;
                    if (i_in_item.sector_count == 32'd0) begin
                        plan.body = BODY_DONE_OK;
                    end else begin
                        n_batch   = st_batch;
                        n_sib     = 9'd0;
                        n_wi      = 8'd0;
                        n_pc      = 20'd0;
                        n_phase   = PH_WAIT_BUSY;
                        plan.body = BODY_STATUS;
                    end
                end
            end
            KIND_STATUS: begin
                case (r_phase)
                    PH_WAIT_BUSY: begin
                        if (!st[ST_BSY]) begin
                            n_phase   = PH_WAIT_DRQ;
                            n_pc      = 20'd0;
                            plan.body = r_lba48 ? BODY_ISSUE48 : BODY_ISSUE28;
                        end else begin
                            do_retry = 1'b1;
                        end
                    end
                    PH_WAIT_DRQ: begin
                        if (st[ST_ERR]) begin
                            n_phase   = PH_IDLE;
                            plan.body = BODY_DONE_ERR;
                        end else if (!st[ST_BSY] && st[ST_DRQ]) begin
                            n_wi = 8'd0;
                            if (r_writing) begin
                                n_phase   = PH_DATA_WRITE;
                                plan.body = BODY_NEED;
                            end else begin
                                n_phase   = PH_DATA_READ;
                                plan.body = BODY_DATARQ;
                            end
                        end else begin
                            do_retry = 1'b1;
                        end
                    end
                    PH_FLUSH_WAIT: begin
                        if (!st[ST_BSY]) begin
                            do_eb = 1'b1;
                        end else begin
                            do_retry = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_DATA: begin
                if (r_phase inside {PH_DATA_READ, PH_DATA_WRITE}) begin
                    plan.head_en = 1'b1;
                    plan.head_op = (r_phase == PH_DATA_READ) ? OP_DELIVER : OP_DATA_WR;
                    if (r_wi == WORD_LAST) begin
                        do_sd = 1'b1;
                    end else begin
                        n_wi = r_wi + 8'd1;
                        if (r_phase == PH_DATA_READ) begin
                            plan.body = BODY_DATARQ;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (do_retry) begin
            n_pc = pc_inc;
            if (pc_inc >= r_poll_limit) begin
                n_phase   = PH_IDLE;
                plan.body = BODY_DONE_ERR;
            end else begin
                plan.body = BODY_STATUS;
            end
        end

        if (do_sd) begin
            n_wi  = 8'd0;
            n_sib = sd_sib;
            if (sd_sib < r_batch) begin
                n_phase   = PH_WAIT_DRQ;
                n_pc      = 20'd0;
                plan.body = BODY_STATUS;
            end else if (r_writing) begin
                n_phase   = PH_FLUSH_WAIT;
                n_pc      = 20'd0;
                plan.body = BODY_FLUSH;
            end else begin
                do_eb = 1'b1;
            end
        end

        if (do_eb) begin
            n_cur_lba = eb_lba;
            n_left    = eb_left;
            if (eb_left == 32'd0) begin
                n_phase   = PH_IDLE;
                plan.body = BODY_DONE_OK;
            end else begin
                n_batch   = eb_batch;
                n_sib     = 9'd0;
                n_wi      = 8'd0;
                n_pc      = 20'd0;
                n_phase   = PH_WAIT_BUSY;
                plan.body = BODY_STATUS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave      <= 1'b0;
            r_lba48      <= 1'b0;
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SLAVE_SELECT: r_slave      <= i_cfg_wdata[0];
                CFG_USE_LBA48:    r_lba48      <= i_cfg_wdata[0];
                CFG_POLL_LIMIT:   r_poll_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_writing <= 1'b0;
            r_cur_lba <= 32'd0;
            r_left    <= 32'd0;
            r_batch   <= 9'd0;
            r_sib     <= 9'd0;
            r_wi      <= 8'd0;
            r_pc      <= 20'd0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_writing <= n_writing;
            r_cur_lba <= n_cur_lba;
            r_left    <= n_left;
            r_batch   <= n_batch;
            r_sib     <= n_sib;
            r_wi      <= n_wi;
            r_pc      <= n_pc;
        end
    end

    atapio_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_plan  (plan),
        .o_free  (emit_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

FILE: src/atapio_emit.sv
// Result sequencer: holds one result plan and presents its results one per cycle while i_ready is high.
`include "assert_macros.svh"

module atapio_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  atapio_pkg::t_plan     i_plan,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output atapio_pkg::t_out_item o_item
);
    import atapio_pkg::*;

    logic       r_active;
    logic [3:0] r_idx;
    t_plan      r_plan;

    logic [3:0] bidx;
    logic [3:0] body_len;
    logic [3:0] total;
    logic       last;

    assign bidx  = r_idx - {3'b000, r_plan.head_en};
    assign total = body_len + {3'b000, r_plan.head_en};
    assign last  = (r_idx == total - 4'd1);

    assign o_valid = r_active;
    assign o_free  = !r_active || (i_ready && last);

    always_comb begin
        case (r_plan.body)
            BODY_STATUS, BODY_DATARQ, BODY_NEED,
            BODY_DONE_OK, BODY_DONE_ERR: body_len = 4'd1;
            BODY_FLUSH:                  body_len = 4'd2;
            BODY_ISSUE28:                body_len = 4'd11;
            BODY_ISSUE48:                body_len = 4'd15;
            default:                     body_len = 4'd0;
        endcase
    end

    always_comb begin
        o_item      = '0;
        o_item.last = last;
        if (r_plan.head_en && r_idx == 4'd0) begin
            o_item.op        = r_plan.head_op;
            o_item.reg_index = REG_DATA;
            o_item.value     = r_plan.head_val;
        end else begin
            case (r_plan.body)
                BODY_STATUS: begin
                    o_item.op        = OP_STATUS_RD;
                    o_item.reg_index = REG_CMD;
                end
                BODY_DATARQ:   o_item.op = OP_DATA_RD;
                BODY_NEED:     o_item.op = OP_NEED_WORDS;
                BODY_DONE_OK:  o_item.op = OP_DONE_OK;
                BODY_DONE_ERR: o_item.op = OP_DONE_ERR;
                BODY_FLUSH: begin
                    o_item.reg_index = REG_CMD;
                    if (bidx == 4'd0) begin
                        o_item.op    = OP_REG_WR;
                        o_item.value = {8'h00, r_plan.lba48 ? CMD_FLUSH48 : CMD_FLUSH28};
                    end else begin
                        o_item.op = OP_STATUS_RD;
                    end
                end
                BODY_ISSUE28: begin
                    case (bidx)
                        4'd0: begin
                            o_item.reg_index = REG_DRIVE;
                            o_item.value     = {8'h00, r_plan.drv};
                        end
                        4'd1, 4'd2, 4'd3, 4'd4: begin
                            o_item.op        = OP_DELAY_RD;
                            o_item.reg_index = REG_CMD;
                        end
                        4'd5: begin
                            o_item.reg_index = REG_COUNT;
                            o_item.value     = {8'h00, r_plan.batch[7:0]};
                        end
                        4'd6: begin
                            o_item.reg_index = REG_LBA_LO;
                            o_item.value     = {8'h00, r_plan.lba[7:0]};
                        end
                        4'd7: begin
                            o_item.reg_index = REG_LBA_MID;
                            o_item.value     = {8'h00, r_plan.lba[15:8]};
                        end
                        4'd8: begin
                            o_item.reg_index = REG_LBA_HI;
                            o_item.value     = {8'h00, r_plan.lba[23:16]};
                        end
                        4'd9: begin
                            o_item.reg_index = REG_CMD;
                            o_item.value     = {8'h00,
                                r_plan.writing ? CMD_WRITE28 : CMD_READ28};
                        end
                        default: begin
                            o_item.op        = OP_STATUS_RD;
                            o_item.reg_index = REG_CMD;
                        end
                    endcase
                end
                BODY_ISSUE48: begin
                    case (bidx)
                        4'd0: begin
                            o_item.reg_index = REG_DRIVE;
                            o_item.value     = {8'h00, r_plan.drv};
                        end
                        4'd1, 4'd2, 4'd3, 4'd4: begin
                            o_item.op        = OP_DELAY_RD;
                            o_item.reg_index = REG_CMD;
                        end
                        4'd5: begin
                            o_item.reg_index = REG_COUNT;
                            o_item.value     = {15'h0000, r_plan.batch[8]};
                        end
                        4'd6: begin
                            o_item.reg_index = REG_LBA_LO;
                            o_item.value     = {8'h00, r_plan.lba[31:24]};
                        end
                        4'd7:  o_item.reg_index = REG_LBA_MID;
                        4'd8:  o_item.reg_index = REG_LBA_HI;
                        4'd9: begin
                            o_item.reg_index = REG_COUNT;
                            o_item.value     = {8'h00, r_plan.batch[7:0]};
                        end
                        4'd10: begin
                            o_item.reg_index = REG_LBA_LO;
                            o_item.value     = {8'h00, r_plan.lba[7:0]};
                        end
                        4'd11: begin
                            o_item.reg_index = REG_LBA_MID;
                            o_item.value     = {8'h00, r_plan.lba[15:8]};
                        end
                        4'd12: begin
                            o_item.reg_index = REG_LBA_HI;
                            o_item.value     = {8'h00, r_plan.lba[23:16]};
                        end
                        4'd13: begin
                            o_item.reg_index = REG_CMD;
                            o_item.value     = {8'h00,
                                r_plan.writing ? CMD_WRITE48 : CMD_READ48};
                        end
                        default: begin
                            o_item.op        = OP_STATUS_RD;
                            o_item.reg_index = REG_CMD;
                        end
                    endcase
                end
                default: o_item = '0;
            endcase
            o_item.last = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 4'd0;
        end else if (i_load && o_free) begin
            r_active <= 1'b1;
            r_idx    <= 4'd0;
        end else if (r_active && i_ready) begin
            if (last) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_plan <= i_plan;
        end
    end

    `ASSERT_CLK(a_idx_in_range, i_clk, i_rst_n, r_active |-> (r_idx < total), "result index past end of plan")
    `ASSERT_CLK(a_load_when_free, i_clk, i_rst_n, i_load |-> o_free, "plan loaded while previous plan still pending")
    `ASSERT_CLK(a_drain_idle, i_clk, i_rst_n, (r_active && i_ready && last && !i_load) |=> !r_active, "sequencer stays busy after final transfer")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ATA PIO sector transfer sequencer.
`timescale 1ns / 100ps

module testbench;
    import atapio_pkg::*;

    localparam int SECTORS_MAX = 256;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_BUSY, PH_WAIT_DRQ, PH_RD, PH_WR, PH_FLUSH
    } t_xfer_phase;

    typedef struct packed {
        t_xfer_phase phase;
        logic        writing;
        logic [31:0] lba;
        logic [31:0] left;
        logic [8:0]  batch;
        logic [8:0]  sec;
        logic [7:0]  widx;
        logic [19:0] polls;
    } t_xfer_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_wdata = '0;

    logic        cfg_slave = 1'b0;
    logic        cfg_lba48 = 1'b0;
    logic [19:0] cfg_poll_limit = POLL_LIMIT_RST;

    t_xfer_state chk_xfer = '0;
    t_xfer_state gen_xfer = '0;
    t_in_item    host_item_q[$];
    t_out_item   bus_op_q[$];

    bit          in_acc = 1'b0;
    int unsigned cyc = 0;
    logic        quiet;
    int          gen_counted = 0;
    int          fail_cnt = 0;
    int          items_taken = 0;
    int          ops_checked = 0;
    int          done_ok_cnt = 0;
    int          done_err_cnt = 0;

    assign quiet = (cyc % 1024) >= 768;

    ata_pio_transfer_sequencer #(.BATCH_SECTORS(SECTORS_MAX)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void add_op(ref t_out_item ops[$], input logic [3:0] op,
                                   input logic [2:0] idx, input logic [15:0] val);
        t_out_item o;
        o.op = op;
        o.reg_index = idx;
        o.value = val;
        o.last = 1'b0;
        ops.push_back(o);
    endfunction

    function automatic void await_status(ref t_xfer_state s, ref t_out_item ops[$],
                                         input t_xfer_phase ph);
        s.phase = ph;
        s.polls = '0;
        add_op(ops, OP_STATUS_RD, REG_CMD, 16'h0);
    endfunction

    function automatic void open_batch(ref t_xfer_state s, ref t_out_item ops[$]);
        s.batch = (s.left > SECTORS_MAX) ? 9'(SECTORS_MAX) : s.left[8:0];
        s.sec = '0;
        s.widx = '0;
        await_status(s, ops, PH_WAIT_BUSY);
    endfunction

    function automatic void close_batch(ref t_xfer_state s, ref t_out_item ops[$]);
        s.lba = s.lba + 32'(s.batch);
        s.left = s.left - 32'(s.batch);
        if (s.left == 0) begin
            s.phase = PH_IDLE;
            add_op(ops, OP_DONE_OK, REG_DATA, 16'h0);
        end else begin
            open_batch(s, ops);
        end
    endfunction

    function automatic void poll_again(ref t_xfer_state s, ref t_out_item ops[$]);
        s.polls = s.polls + 20'd1;
        if (s.polls >= cfg_poll_limit) begin
            s.phase = PH_IDLE;
            add_op(ops, OP_DONE_ERR, REG_DATA, 16'h0);
        end else begin
            add_op(ops, OP_STATUS_RD, REG_CMD, 16'h0);
        end
    endfunction

    // Bus operations caused by one host item, in issue order.
    function automatic void predict_bus_ops(ref t_xfer_state s, input t_in_item it,
                                            ref t_out_item ops[$]);
        logic [7:0] st;
        logic [7:0] drv;
        ops.delete();
        st = it.status_byte;
        case (it.kind)
            KIND_START: begin
                if (s.phase == PH_IDLE) begin
                    s.writing = it.write_dir;
                    s.lba = it.start_lba;
                    s.left = it.sector_count;
                    if (s.left == 0)
                        add_op(ops, OP_DONE_OK, REG_DATA, 16'h0);
                    else
                        open_batch(s, ops);
                end
            end
            KIND_STATUS: begin
                case (s.phase)
                    PH_WAIT_BUSY: begin
                        if (!st[ST_BSY]) begin
                            drv = DRV_BASE | (cfg_slave ? DRV_SLAVE : 8'h00);
                            if (!cfg_lba48)
                                drv = drv | {4'h0, s.lba[27:24]};
                            add_op(ops, OP_REG_WR, REG_DRIVE, {8'h00, drv});
                            repeat (4) add_op(ops, OP_DELAY_RD, REG_CMD, 16'h0);
                            if (cfg_lba48) begin
                                add_op(ops, OP_REG_WR, REG_COUNT, {15'd0, s.batch[8]});
                                add_op(ops, OP_REG_WR, REG_LBA_LO, {8'h00, s.lba[31:24]});
                                add_op(ops, OP_REG_WR, REG_LBA_MID, 16'h0);
                                add_op(ops, OP_REG_WR, REG_LBA_HI, 16'h0);
                            end
                            add_op(ops, OP_REG_WR, REG_COUNT, {8'h00, s.batch[7:0]});
                            add_op(ops, OP_REG_WR, REG_LBA_LO, {8'h00, s.lba[7:0]});
                            add_op(ops, OP_REG_WR, REG_LBA_MID, {8'h00, s.lba[15:8]});
                            add_op(ops, OP_REG_WR, REG_LBA_HI, {8'h00, s.lba[23:16]});
                            if (cfg_lba48)
                                add_op(ops, OP_REG_WR, REG_CMD,
                                       {8'h00, s.writing ? CMD_WRITE48 : CMD_READ48});
                            else
                                add_op(ops, OP_REG_WR, REG_CMD,
                                       {8'h00, s.writing ? CMD_WRITE28 : CMD_READ28});
                            await_status(s, ops, PH_WAIT_DRQ);
                        end else begin
                            poll_again(s, ops);
                        end
                    end
                    PH_WAIT_DRQ: begin
                        if (st[ST_ERR]) begin
                            s.phase = PH_IDLE;
                            add_op(ops, OP_DONE_ERR, REG_DATA, 16'h0);
                        end else if (!st[ST_BSY] && st[ST_DRQ]) begin
                            s.widx = '0;
                            if (s.writing) begin
                                s.phase = PH_WR;
                                add_op(ops, OP_NEED_WORDS, REG_DATA, 16'h0);
                            end else begin
                                s.phase = PH_RD;
                                add_op(ops, OP_DATA_RD, REG_DATA, 16'h0);
                            end
                        end else begin
                            poll_again(s, ops);
                        end
                    end
                    PH_FLUSH: begin
                        if (!st[ST_BSY])
                            close_batch(s, ops);
                        else
                            poll_again(s, ops);
                    end
                    default: ;
                endcase
            end
            KIND_DATA: begin
                if (s.phase inside {PH_RD, PH_WR}) begin
                    add_op(ops, (s.phase == PH_RD) ? OP_DELIVER : OP_DATA_WR, REG_DATA,
                           it.data_word);
                    if (s.widx == WORD_LAST) begin
                        s.widx = '0;
                        s.sec = s.sec + 9'd1;
                        if (s.sec < s.batch) begin
                            await_status(s, ops, PH_WAIT_DRQ);
                        end else if (s.writing) begin
                            add_op(ops, OP_REG_WR, REG_CMD,
                                   {8'h00, cfg_lba48 ? CMD_FLUSH48 : CMD_FLUSH28});
                            await_status(s, ops, PH_FLUSH);
                        end else begin
                            close_batch(s, ops);
                        end
                    end else begin
                        s.widx = s.widx + 8'd1;
                        if (s.phase == PH_RD)
                            add_op(ops, OP_DATA_RD, REG_DATA, 16'h0);
                    end
                end
            end
            default: ;
        endcase
        if (ops.size() > 0)
            ops[ops.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_in_item mk_item(input logic [1:0] kind, input logic wr,
                                         input logic [31:0] lba, input logic [31:0] cnt,
                                         input logic [7:0] st, input logic [15:0] word);
        t_in_item it;
        it.kind = kind;
        it.write_dir = wr;
        it.start_lba = lba;
        it.sector_count = cnt;
        it.status_byte = st;
        it.data_word = word;
        return it;
    endfunction

    function automatic void enqueue(input t_in_item it);
        t_out_item ops[$];
        predict_bus_ops(gen_xfer, it, ops);
        if (ops.size() > 0)
            gen_counted++;
        host_item_q.push_back(it);
    endfunction

    // Mostly the reply the engine is waiting for, sometimes a stray item.
    // Without long_ok the drive never offers data, so each transfer of one or more sectors ends in error.
    function automatic t_in_item next_host_item(input t_xfer_state g, input int err_pct,
                                                input bit long_ok);
        t_in_item it;
        int pick;
        it = mk_item(KIND_START, 1'($urandom_range(1)), $urandom(), $urandom(),
                     8'($urandom()), 16'($urandom()));
        pick = $urandom_range(99);
        if (pick < 6) begin
            pick = $urandom_range(2);
            case (g.phase)
                PH_IDLE:
                    it.kind = (pick == 0) ? KIND_STATUS : (pick == 1) ? KIND_DATA : KIND_NONE;
                PH_WAIT_BUSY, PH_WAIT_DRQ, PH_FLUSH:
                    it.kind = (pick == 0) ? KIND_START : (pick == 1) ? KIND_DATA : KIND_NONE;
                default:
                    it.kind = (pick == 0) ? KIND_START : (pick == 1) ? KIND_STATUS : KIND_NONE;
            endcase
        end else begin
            case (g.phase)
                PH_IDLE: begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        it.sector_count = 32'd0;
                    else if (pick < 75)
                        it.sector_count = $urandom_range(2, 1);
                    else if (pick < 80)
                        it.sector_count = 32'd3;
                    pick = $urandom_range(9);
                    if (pick == 0)
                        it.start_lba = 32'hFFFF_FFFF;
                    else if (pick == 1)
                        it.start_lba = 32'h0;
                    else if (pick == 2)
                        it.start_lba = 32'h0FFF_FFFE;
                end
                PH_WAIT_BUSY, PH_FLUSH: begin
                    it.kind = KIND_STATUS;
                    it.status_byte[ST_BSY] = ($urandom_range(99) < 30);
                end
                PH_WAIT_DRQ: begin
                    it.kind = KIND_STATUS;
                    it.status_byte[ST_ERR] = 1'b0;
                    if ($urandom_range(99) < err_pct) begin
                        it.status_byte[ST_ERR] = 1'b1;
                    end else if (!long_ok || $urandom_range(99) < 30) begin
                        if ($urandom_range(1))
                            it.status_byte[ST_BSY] = 1'b1;
                        else
                            it.status_byte[ST_DRQ] = 1'b0;
                    end else begin
                        it.status_byte[ST_BSY] = 1'b0;
                        it.status_byte[ST_DRQ] = 1'b1;
                    end
                end
                default: begin
                    it.kind = KIND_DATA;
                    if ($urandom_range(9) == 0)
                        it.data_word = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
            endcase
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (host_item_q.size() != 0 || i_in_valid || bus_op_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic slave, input logic lba48, input logic [19:0] limit);
        write_reg(CFG_SLAVE_SELECT, {19'd0, slave});
        write_reg(CFG_USE_LBA48, {19'd0, lba48});
        write_reg(CFG_POLL_LIMIT, limit);
        cfg_slave = slave;
        cfg_lba48 = lba48;
        cfg_poll_limit = limit;
    endtask

    task automatic run_random(input int n, input int err_pct, input bit long_ok);
        gen_counted = 0;
        while (gen_counted < n || gen_xfer.phase != PH_IDLE)
            enqueue(next_host_item(gen_xfer, err_pct, long_ok));
        wait_drained();
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_acc) begin
            if (host_item_q.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
                i_in_item <= host_item_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && (quiet || $urandom_range(99) >= 16);
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_out_item exp_op;
        t_out_item new_ops[$];
        cyc <= cyc + 1;
        in_acc = i_rst_n && i_in_valid && o_in_ready;
        if (in_acc) begin
            items_taken++;
            predict_bus_ops(chk_xfer, i_in_item, new_ops);
            foreach (new_ops[k])
                bus_op_q.push_back(new_ops[k]);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bus_op_q.size() == 0) begin
                $error("unexpected result: op %0d reg %0d value 0x%04h",
                       o_out_item.op, o_out_item.reg_index, o_out_item.value);
                fail_cnt++;
            end else begin
                exp_op = bus_op_q.pop_front();
                ops_checked++;
                if (exp_op.op == OP_DONE_OK)
                    done_ok_cnt++;
                if (exp_op.op == OP_DONE_ERR)
                    done_err_cnt++;
                if (o_out_item.op !== exp_op.op) begin
                    $error("op: expected %0d, got %0d", exp_op.op, o_out_item.op);
                    fail_cnt++;
                end
                if (o_out_item.reg_index !== exp_op.reg_index) begin
                    $error("reg_index: expected %0d, got %0d",
                           exp_op.reg_index, o_out_item.reg_index);
                    fail_cnt++;
                end
                if (o_out_item.value !== exp_op.value) begin
                    $error("value: expected 0x%04h, got 0x%04h", exp_op.value, o_out_item.value);
                    fail_cnt++;
                end
                if (o_out_item.last !== exp_op.last) begin
                    $error("last: expected %0d, got %0d", exp_op.last, o_out_item.last);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: LBA28, master, default poll limit
        enqueue(mk_item(KIND_START, 1'b0, 32'h0000_1000, 32'd0, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_DATA, 1'b1, 32'h0, 32'h0, 8'h00, 16'h1234));
        enqueue(mk_item(KIND_START, 1'b0, 32'hFFFF_FFFF, 32'd300, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'hFF, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h7F, 16'h0000));
        enqueue(mk_item(KIND_DATA, 1'b0, 32'h0, 32'h0, 8'h00, 16'hFFFF));
        enqueue(mk_item(KIND_START, 1'b1, 32'h0, 32'd5, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h89, 16'h0000));
        wait_drained();

        // LBA48, slave, two polls per wait
        set_config(1'b1, 1'b1, 20'd2);
        enqueue(mk_item(KIND_START, 1'b1, 32'h8765_4321, 32'hFFFF_FFFF, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h88, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_START, 1'b0, 32'h0, 32'd1, 8'h00, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'h80, 16'h0000));
        enqueue(mk_item(KIND_STATUS, 1'b0, 32'h0, 32'h0, 8'hF6, 16'h0000));
        wait_drained();

        set_config(1'b0, 1'b0, 20'hFFFFF);
        run_random(30, 40, 1'b0);
        set_config(1'b1, 1'b0, 20'd1);
        run_random(30, 40, 1'b0);
        set_config(1'b0, 1'b1, 20'($urandom_range(6, 2)));
        run_random(30, 40, 1'b0);
        set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 20'($urandom_range(50, 3)));
        run_random(30, 40, 1'b0);

        // one full sector written, then flushed
        set_config(1'b1, 1'b1, 20'hFFFFF);
        enqueue(mk_item(KIND_START, 1'b1, 32'hFFFF_FFFF, 32'd1, 8'h00, 16'h0000));
        run_random(0, 0, 1'b1);

        $display("summary: %0d host items taken, %0d bus ops checked", items_taken, ops_checked);
        $display("summary: %0d transfers done ok, %0d ended in error, %0d mismatches",
                 done_ok_cnt, done_err_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
